FILE: src/rbm_pkg.sv
// Shared widths, status codes and pipeline context for the 2x2 block square root.
package rbm_pkg;

    localparam int ENTRY_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;

    // Square root radicand must hold a product of two entries and the widest shifted sum.
    localparam int SQ_RAW = (2 * ENTRY_WIDTH > ENTRY_WIDTH + FRACTION_BITS + 2) ?
                            2 * ENTRY_WIDTH : ENTRY_WIDTH + FRACTION_BITS + 2;
    localparam int SQ_W   = SQ_RAW + (SQ_RAW % 2);
    localparam int RT_W   = SQ_W / 2;
    localparam int NUM_W  = ENTRY_WIDTH + FRACTION_BITS;
    localparam int DV_W   = RT_W + 1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NEG_RADICAND = 2'd1,
        ST_ZERO_DIV     = 2'd2,
        ST_SATURATED    = 2'd3
    } t_status;

    typedef struct packed {
        logic [3:0]             neg;
        logic [ENTRY_WIDTH-1:0] mag0;
        logic [ENTRY_WIDTH-1:0] mag1;
        logic [ENTRY_WIDTH-1:0] mag2;
        logic [ENTRY_WIDTH-1:0] mag3;
        logic                   quasi;
        logic                   pos;
        t_status                status;
        logic [RT_W-1:0]        mu;
        logic [RT_W-1:0]        s1;
        logic [RT_W-1:0]        s4;
        logic [RT_W-1:0]        hyp;
        logic [RT_W-1:0]        root3;
        logic [ENTRY_WIDTH-1:0] alpha;
    } t_ctx;

    typedef struct packed {
        logic [ENTRY_WIDTH-1:0] r0;
        logic [ENTRY_WIDTH-1:0] r1;
        logic [ENTRY_WIDTH-1:0] r2;
        logic [ENTRY_WIDTH-1:0] r3;
        t_status                status;
    } t_res;

    function automatic logic [ENTRY_WIDTH-1:0] mag_of(input logic [ENTRY_WIDTH-1:0] v);
        logic [ENTRY_WIDTH-1:0] m;
        m = v[ENTRY_WIDTH-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

endpackage

FILE: src/rbm_if.sv
// Valid/ready channels for the input block word and the result word.
interface rbm_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [rbm_pkg::ENTRY_WIDTH-1:0]   top_left;
    logic signed [rbm_pkg::ENTRY_WIDTH-1:0]   top_right;
    logic signed [rbm_pkg::ENTRY_WIDTH-1:0]   bottom_left;
    logic signed [rbm_pkg::ENTRY_WIDTH-1:0]   bottom_right;

    modport source (output valid, top_left, top_right, bottom_left, bottom_right,
                    input ready);
    modport sink   (input valid, top_left, top_right, bottom_left, bottom_right,
                    output ready);
endinterface

interface rbm_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [rbm_pkg::ENTRY_WIDTH-1:0]   root_top_left;
    logic signed [rbm_pkg::ENTRY_WIDTH-1:0]   root_top_right;
    logic signed [rbm_pkg::ENTRY_WIDTH-1:0]   root_bottom_left;
    logic signed [rbm_pkg::ENTRY_WIDTH-1:0]   root_bottom_right;
    logic        [1:0]                        status;

    modport source (output valid, root_top_left, root_top_right, root_bottom_left,
                    root_bottom_right, status, input ready);
    modport sink   (input valid, root_top_left, root_top_right, root_bottom_left,
                    root_bottom_right, status, output ready);
endinterface

FILE: src/rbm_isqrt.sv
// Pipelined integer square root, one root bit per stage, context carried alongside.
module rbm_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic [rbm_pkg::SQ_W-1:0] i_rad,
    input  rbm_pkg::t_ctx            i_ctx,
    output logic                     o_vld,
    output logic [rbm_pkg::RT_W-1:0] o_root,
    output rbm_pkg::t_ctx            o_ctx
);
    logic [rbm_pkg::RT_W-1:0] r_vld;
    logic [rbm_pkg::SQ_W-1:0] r_rad  [rbm_pkg::RT_W];
    logic [rbm_pkg::RT_W+1:0] r_rem  [rbm_pkg::RT_W];
    logic [rbm_pkg::RT_W-1:0] r_root [rbm_pkg::RT_W];
    rbm_pkg::t_ctx            r_ctx  [rbm_pkg::RT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[rbm_pkg::RT_W-2:0], i_vld};
        end
    end

    for (genvar k = 0; k < rbm_pkg::RT_W; k++) begin : g_stage
        logic [rbm_pkg::SQ_W-1:0] rad_in;
        logic [rbm_pkg::RT_W+1:0] rem_in;
        logic [rbm_pkg::RT_W-1:0] root_in;
        rbm_pkg::t_ctx            ctx_in;
        logic [rbm_pkg::RT_W+3:0] acc;
        logic [rbm_pkg::RT_W+3:0] trial;
        logic [rbm_pkg::RT_W+1:0] n_rem;
        logic [rbm_pkg::RT_W-1:0] n_root;

        if (k == 0) begin : g_head
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign ctx_in  = i_ctx;
        end else begin : g_body
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign ctx_in  = r_ctx[k-1];
        end

        always_comb begin
            // bring down the next radicand bit pair, try root*4+1
            acc   = {rem_in, rad_in[rbm_pkg::SQ_W-1 -: 2]};
            trial = (rbm_pkg::RT_W+4)'({root_in, 2'b01});
            if (acc >= trial) begin
                n_rem  = (rbm_pkg::RT_W+2)'(acc - trial);
                n_root = {root_in[rbm_pkg::RT_W-2:0], 1'b1};
            end else begin
                n_rem  = (rbm_pkg::RT_W+2)'(acc);
                n_root = {root_in[rbm_pkg::RT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= rad_in << 2;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_ctx[k]  <= ctx_in;
            end
        end
    end

    assign o_vld  = r_vld[rbm_pkg::RT_W-1];
    assign o_root = r_root[rbm_pkg::RT_W-1];
    assign o_ctx  = r_ctx[rbm_pkg::RT_W-1];

endmodule

FILE: src/rbm_div.sv
// Pipelined restoring divider, one quotient bit per stage, context carried alongside.
module rbm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [rbm_pkg::NUM_W-1:0] i_num,
    input  logic [rbm_pkg::DV_W-1:0]  i_den,
    input  rbm_pkg::t_ctx             i_ctx,
    output logic                      o_vld,
    output logic [rbm_pkg::NUM_W-1:0] o_quo,
    output rbm_pkg::t_ctx             o_ctx
);
    logic [rbm_pkg::NUM_W-1:0] r_vld;
    logic [rbm_pkg::NUM_W-1:0] r_num [rbm_pkg::NUM_W];
    logic [rbm_pkg::DV_W-1:0]  r_den [rbm_pkg::NUM_W];
    logic [rbm_pkg::DV_W-1:0]  r_rem [rbm_pkg::NUM_W];
    logic [rbm_pkg::NUM_W-1:0] r_quo [rbm_pkg::NUM_W];
    rbm_pkg::t_ctx             r_ctx [rbm_pkg::NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[rbm_pkg::NUM_W-2:0], i_vld};
        end
    end

    for (genvar k = 0; k < rbm_pkg::NUM_W; k++) begin : g_stage
        logic [rbm_pkg::NUM_W-1:0] num_in;
        logic [rbm_pkg::DV_W-1:0]  den_in;
        logic [rbm_pkg::DV_W-1:0]  rem_in;
        logic [rbm_pkg::NUM_W-1:0] quo_in;
        rbm_pkg::t_ctx             ctx_in;
        logic [rbm_pkg::DV_W:0]    acc;
        logic [rbm_pkg::DV_W-1:0]  n_rem;
        logic [rbm_pkg::NUM_W-1:0] n_quo;

        if (k == 0) begin : g_head
            assign num_in = i_num;
            assign den_in = i_den;
            assign rem_in = '0;
            assign quo_in = '0;
            assign ctx_in = i_ctx;
        end else begin : g_body
            assign num_in = r_num[k-1];
            assign den_in = r_den[k-1];
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign ctx_in = r_ctx[k-1];
        end

        always_comb begin
            acc = {rem_in, num_in[rbm_pkg::NUM_W-1]};
            if (acc >= (rbm_pkg::DV_W+1)'(den_in)) begin
                n_rem = rbm_pkg::DV_W'(acc - (rbm_pkg::DV_W+1)'(den_in));
                n_quo = {quo_in[rbm_pkg::NUM_W-2:0], 1'b1};
            end else begin
                n_rem = rbm_pkg::DV_W'(acc);
                n_quo = {quo_in[rbm_pkg::NUM_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= num_in << 1;
                r_den[k] <= den_in;
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_ctx[k] <= ctx_in;
            end
        end
    end

    assign o_vld = r_vld[rbm_pkg::NUM_W-1];
    assign o_quo = r_quo[rbm_pkg::NUM_W-1];
    assign o_ctx = r_ctx[rbm_pkg::NUM_W-1];

endmodule

FILE: src/real_2x2_block_matrix_sqrt.sv
// Principal square root of a 2x2 real Schur block, fully pipelined.
//
// Input channel i_blk carries one block word (four signed Q16.16 entries);
// output channel o_root carries the root word (four Q16.16 entries and a
// status code: ok, negative radicand, zero divisor, saturated). A flagged
// word carries all four entries as zero.
// One word is accepted every cycle while ready is high. From accept to
// output valid, each Q16.16 word passes through three bit-per-stage square
// root pipelines (mu, hyp, alpha or its denominator) and two bit-per-stage
// dividers (the negative-branch alpha, then the off-diagonal quotients).
// Every stage advances together; a two-entry output register/skid holds
// results, so a word is still accepted while one result waits. When the
// receiver stalls and the skid slot is full, the whole pipeline holds and
// ready drops; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits but not the output
// data register; the first word may be presented in the cycle after reset.
module real_2x2_block_matrix_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbm_in_if.sink      i_blk,
    rbm_out_if.source   o_root
);
    logic adv;

    // stage 0: magnitudes, signs, radicand sign check
    rbm_pkg::t_ctx n0_ctx, r0_ctx;
    logic          r0_vld;

    always_comb begin
        n0_ctx       = '0;
        n0_ctx.neg   = {i_blk.bottom_right[rbm_pkg::ENTRY_WIDTH-1],
                        i_blk.bottom_left[rbm_pkg::ENTRY_WIDTH-1],
                        i_blk.top_right[rbm_pkg::ENTRY_WIDTH-1],
                        i_blk.top_left[rbm_pkg::ENTRY_WIDTH-1]};
        n0_ctx.mag0  = rbm_pkg::mag_of(i_blk.top_left);
        n0_ctx.mag1  = rbm_pkg::mag_of(i_blk.top_right);
        n0_ctx.mag2  = rbm_pkg::mag_of(i_blk.bottom_left);
        n0_ctx.mag3  = rbm_pkg::mag_of(i_blk.bottom_right);
        n0_ctx.quasi = (n0_ctx.mag2 != '0);
        n0_ctx.pos   = !n0_ctx.neg[0] && (n0_ctx.mag0 != '0);
        n0_ctx.status = rbm_pkg::ST_OK;
        if (n0_ctx.quasi) begin
            if ((n0_ctx.mag1 != '0) && (n0_ctx.neg[1] == n0_ctx.neg[2])) begin
                n0_ctx.status = rbm_pkg::ST_NEG_RADICAND;
            end
        end else if (n0_ctx.neg[0] || n0_ctx.neg[3]) begin
            n0_ctx.status = rbm_pkg::ST_NEG_RADICAND;
        end
    end

    // stage 1: a12*a21 for mu, or the shifted diagonals for the triangular roots
    logic [2*rbm_pkg::ENTRY_WIDTH-1:0] s1_prod;
    rbm_pkg::t_ctx                     r1_ctx;
    logic                              r1_vld;
    logic [rbm_pkg::SQ_W-1:0]          r1_rad_a, r1_rad_b;

    assign s1_prod = (2*rbm_pkg::ENTRY_WIDTH)'(r0_ctx.mag1) *
                     (2*rbm_pkg::ENTRY_WIDTH)'(r0_ctx.mag2);

    // stage 2/3: squares and their sum for hyp
    logic                              u1_vld;
    logic [rbm_pkg::RT_W-1:0]          u1_root, u1b_root;
    rbm_pkg::t_ctx                     u1_ctx, n2_ctx, r2_ctx, r3_ctx;
    logic                              r2_vld, r3_vld;
    logic [2*rbm_pkg::ENTRY_WIDTH-1:0] r2_sq0, r2_sqm;
    logic [rbm_pkg::SQ_W-1:0]          r3_rad;
    logic [rbm_pkg::ENTRY_WIDTH-1:0]   mu_e;

    assign mu_e = u1_root[rbm_pkg::ENTRY_WIDTH-1:0];

    always_comb begin
        n2_ctx    = u1_ctx;
        n2_ctx.s4 = u1b_root;
        if (u1_ctx.quasi) begin
            n2_ctx.mu = u1_root;
        end else begin
            n2_ctx.s1 = u1_root;
        end
    end

    // stage 4: radicand of alpha (positive a11) or of its denominator
    logic                     u2_vld;
    logic [rbm_pkg::RT_W-1:0] u2_root;
    rbm_pkg::t_ctx            u2_ctx, n4_ctx, r4_ctx;
    logic                     r4_vld;
    logic [rbm_pkg::RT_W:0]   s4_sum;
    logic [rbm_pkg::SQ_W-1:0] n4_rad, r4_rad;

    always_comb begin
        n4_ctx     = u2_ctx;
        n4_ctx.hyp = u2_root;
        s4_sum     = (rbm_pkg::RT_W+1)'(u2_ctx.mag0) + (rbm_pkg::RT_W+1)'(u2_root);
        if (u2_ctx.pos) begin
            n4_rad = rbm_pkg::SQ_W'(s4_sum) << (rbm_pkg::FRACTION_BITS - 1);
        end else begin
            n4_rad = rbm_pkg::SQ_W'(s4_sum) << (rbm_pkg::FRACTION_BITS + 1);
        end
    end

    // stage 5: denominator check, feed mu / den
    logic                      u3_vld;
    logic [rbm_pkg::RT_W-1:0]  u3_root;
    rbm_pkg::t_ctx             u3_ctx, n5_ctx, r5_ctx;
    logic                      r5_vld;
    logic [rbm_pkg::NUM_W-1:0] r5_num;
    logic [rbm_pkg::DV_W-1:0]  r5_den;

    always_comb begin
        n5_ctx       = u3_ctx;
        n5_ctx.root3 = u3_root;
        if (u3_ctx.quasi && !u3_ctx.pos && (u3_root == '0) &&
            (u3_ctx.status == rbm_pkg::ST_OK)) begin
            n5_ctx.status = rbm_pkg::ST_ZERO_DIV;
        end
    end

    // stage 6: pick alpha, range and zero checks, divisor for the off-diagonals
    logic                      d1_vld;
    logic [rbm_pkg::NUM_W-1:0] d1_quo;
    rbm_pkg::t_ctx             d1_ctx, n6_ctx, r6_ctx;
    logic                      r6_vld;
    logic                      q_big, root_big, s1_big, s4_big;
    logic [rbm_pkg::DV_W-1:0]  n6_den, r6_den;
    logic [rbm_pkg::NUM_W-1:0] r6_num_a, r6_num_b;

    assign q_big    = |d1_quo[rbm_pkg::NUM_W-1:rbm_pkg::ENTRY_WIDTH-1];
    assign root_big = |d1_ctx.root3[rbm_pkg::RT_W-1:rbm_pkg::ENTRY_WIDTH-1];
    assign s1_big   = |d1_ctx.s1[rbm_pkg::RT_W-1:rbm_pkg::ENTRY_WIDTH-1];
    assign s4_big   = |d1_ctx.s4[rbm_pkg::RT_W-1:rbm_pkg::ENTRY_WIDTH-1];

    always_comb begin
        n6_ctx       = d1_ctx;
        n6_ctx.alpha = d1_ctx.pos ? d1_ctx.root3[rbm_pkg::ENTRY_WIDTH-1:0]
                                  : d1_quo[rbm_pkg::ENTRY_WIDTH-1:0];
        if (d1_ctx.status == rbm_pkg::ST_OK) begin
            if (d1_ctx.quasi) begin
                if (d1_ctx.pos ? root_big : q_big) begin
                    n6_ctx.status = rbm_pkg::ST_SATURATED;
                end else if (n6_ctx.alpha == '0) begin
                    n6_ctx.status = rbm_pkg::ST_ZERO_DIV;
                end
            end else if ((d1_ctx.s1 == '0) && (d1_ctx.s4 == '0)) begin
                n6_ctx.status = rbm_pkg::ST_ZERO_DIV;
            end else if (s1_big || s4_big) begin
                n6_ctx.status = rbm_pkg::ST_SATURATED;
            end
        end
        if (d1_ctx.quasi) begin
            n6_den = rbm_pkg::DV_W'({n6_ctx.alpha, 1'b0});
        end else begin
            n6_den = rbm_pkg::DV_W'(d1_ctx.s1) + rbm_pkg::DV_W'(d1_ctx.s4);
        end
    end

    // result: quotient range checks, sign restore, flagged words zeroed
    logic                                d2_vld;
    logic [rbm_pkg::NUM_W-1:0]           d2a_quo, d2b_quo;
    rbm_pkg::t_ctx                       d2_ctx;
    logic [rbm_pkg::FRACTION_BITS:0]     hi_a, hi_b;
    logic                                fit_a, fit_b;
    logic [rbm_pkg::ENTRY_WIDTH-1:0]     lo_a, lo_b;
    rbm_pkg::t_res                       c_res;

    assign hi_a = d2a_quo[rbm_pkg::NUM_W-1:rbm_pkg::ENTRY_WIDTH-1];
    assign hi_b = d2b_quo[rbm_pkg::NUM_W-1:rbm_pkg::ENTRY_WIDTH-1];
    assign lo_a = d2a_quo[rbm_pkg::ENTRY_WIDTH-1:0];
    assign lo_b = d2b_quo[rbm_pkg::ENTRY_WIDTH-1:0];

    always_comb begin
        // a negative quotient may reach exactly half the range
        fit_a = (hi_a == '0) || (d2_ctx.neg[1] && (hi_a == (rbm_pkg::FRACTION_BITS+1)'(1)) &&
                                 (d2a_quo[rbm_pkg::ENTRY_WIDTH-2:0] == '0));
        fit_b = (hi_b == '0) || (d2_ctx.neg[2] && (hi_b == (rbm_pkg::FRACTION_BITS+1)'(1)) &&
                                 (d2b_quo[rbm_pkg::ENTRY_WIDTH-2:0] == '0));
        c_res.status = d2_ctx.status;
        if ((d2_ctx.status == rbm_pkg::ST_OK) && (!fit_a || (d2_ctx.quasi && !fit_b))) begin
            c_res.status = rbm_pkg::ST_SATURATED;
        end
        c_res.r1 = d2_ctx.neg[1] ? (~lo_a + 1'b1) : lo_a;
        if (d2_ctx.quasi) begin
            c_res.r0 = d2_ctx.alpha;
            c_res.r3 = d2_ctx.alpha;
            c_res.r2 = d2_ctx.neg[2] ? (~lo_b + 1'b1) : lo_b;
        end else begin
            c_res.r0 = d2_ctx.s1[rbm_pkg::ENTRY_WIDTH-1:0];
            c_res.r3 = d2_ctx.s4[rbm_pkg::ENTRY_WIDTH-1:0];
            c_res.r2 = '0;
        end
        if (c_res.status != rbm_pkg::ST_OK) begin
            c_res.r0 = '0;
            c_res.r1 = '0;
            c_res.r2 = '0;
            c_res.r3 = '0;
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (adv) begin
            r0_vld <= i_blk.valid;
            r1_vld <= r0_vld;
            r2_vld <= u1_vld;
            r3_vld <= r2_vld;
            r4_vld <= u2_vld;
            r5_vld <= u3_vld;
            r6_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_ctx   <= n0_ctx;
            r1_ctx   <= r0_ctx;
            r1_rad_a <= r0_ctx.quasi ? rbm_pkg::SQ_W'(s1_prod)
                        : rbm_pkg::SQ_W'({r0_ctx.mag0, {rbm_pkg::FRACTION_BITS{1'b0}}});
            r1_rad_b <= rbm_pkg::SQ_W'({r0_ctx.mag3, {rbm_pkg::FRACTION_BITS{1'b0}}});
            r2_ctx   <= n2_ctx;
            r2_sq0   <= (2*rbm_pkg::ENTRY_WIDTH)'(u1_ctx.mag0) *
                        (2*rbm_pkg::ENTRY_WIDTH)'(u1_ctx.mag0);
            r2_sqm   <= (2*rbm_pkg::ENTRY_WIDTH)'(mu_e) * (2*rbm_pkg::ENTRY_WIDTH)'(mu_e);
            r3_ctx   <= r2_ctx;
            r3_rad   <= rbm_pkg::SQ_W'(r2_sq0) + rbm_pkg::SQ_W'(r2_sqm);
            r4_ctx   <= n4_ctx;
            r4_rad   <= n4_rad;
            r5_ctx   <= n5_ctx;
            r5_num   <= {u3_ctx.mu[rbm_pkg::ENTRY_WIDTH-1:0], {rbm_pkg::FRACTION_BITS{1'b0}}};
            r5_den   <= rbm_pkg::DV_W'(u3_root);
            r6_ctx   <= n6_ctx;
            r6_den   <= n6_den;
            r6_num_a <= {d1_ctx.mag1, {rbm_pkg::FRACTION_BITS{1'b0}}};
            r6_num_b <= {d1_ctx.mag2, {rbm_pkg::FRACTION_BITS{1'b0}}};
        end
    end

    rbm_isqrt u_sqrt_mu (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv),
        .i_vld (r1_vld), .i_rad (r1_rad_a), .i_ctx (r1_ctx),
        .o_vld (u1_vld), .o_root (u1_root), .o_ctx (u1_ctx)
    );

    rbm_isqrt u_sqrt_s4 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv),
        .i_vld (r1_vld), .i_rad (r1_rad_b), .i_ctx (r1_ctx),
        .o_vld (), .o_root (u1b_root), .o_ctx ()
    );

    rbm_isqrt u_sqrt_hyp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv),
        .i_vld (r3_vld), .i_rad (r3_rad), .i_ctx (r3_ctx),
        .o_vld (u2_vld), .o_root (u2_root), .o_ctx (u2_ctx)
    );

    rbm_isqrt u_sqrt_alpha (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv),
        .i_vld (r4_vld), .i_rad (r4_rad), .i_ctx (r4_ctx),
        .o_vld (u3_vld), .o_root (u3_root), .o_ctx (u3_ctx)
    );

    rbm_div u_div_alpha (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv),
        .i_vld (r5_vld), .i_num (r5_num), .i_den (r5_den), .i_ctx (r5_ctx),
        .o_vld (d1_vld), .o_quo (d1_quo), .o_ctx (d1_ctx)
    );

    rbm_div u_div_upper (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv),
        .i_vld (r6_vld), .i_num (r6_num_a), .i_den (r6_den), .i_ctx (r6_ctx),
        .o_vld (d2_vld), .o_quo (d2a_quo), .o_ctx (d2_ctx)
    );

    rbm_div u_div_lower (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (adv),
        .i_vld (r6_vld), .i_num (r6_num_b), .i_den (r6_den), .i_ctx (r6_ctx),
        .o_vld (), .o_quo (d2b_quo), .o_ctx ()
    );

    // output register plus one skid slot
    rbm_pkg::t_res r_out, r_hold;
    logic          r_ov, r_hv;

    assign adv = !r_hv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_hv <= 1'b0;
        end else if (!r_hv) begin
            if (!r_ov || o_root.ready) begin
                r_ov <= d2_vld;
            end else if (d2_vld) begin
                r_hv <= 1'b1;
            end
        end else if (o_root.ready) begin
            r_hv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_hv) begin
            if (!r_ov || o_root.ready) begin
                r_out <= c_res;
            end else begin
                r_hold <= c_res;
            end
        end else if (o_root.ready) begin
            // drain the held word into the output register
            r_out <= r_hold;
        end
    end

    assign i_blk.ready              = adv;
    assign o_root.valid             = r_ov;
    assign o_root.root_top_left     = r_out.r0;
    assign o_root.root_top_right    = r_out.r1;
    assign o_root.root_bottom_left  = r_out.r2;
    assign o_root.root_bottom_right = r_out.r3;
    assign o_root.status            = r_out.status;

    a_hold_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hv |-> r_ov)
        else $error("skid word held while output register empty");

    a_hold_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hv && o_root.ready) |=> (r_ov && !r_hv))
        else $error("held word not moved to output after it was taken");

    a_flag_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_out.status != rbm_pkg::ST_OK)) |->
        ((r_out.r0 == '0) && (r_out.r1 == '0) && (r_out.r2 == '0) && (r_out.r3 == '0)))
        else $error("flagged word carries nonzero entries");

    a_diag_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_out.status == rbm_pkg::ST_OK)) |->
        (!r_out.r0[rbm_pkg::ENTRY_WIDTH-1] && !r_out.r3[rbm_pkg::ENTRY_WIDTH-1]))
        else $error("root diagonal negative on a good word");

endmodule
